// ----- hdl/dpr_pkg.sv -----
// Package for the dual-channel PWM ramp controller with overcurrent cutback.
// Holds the request/response structs, command and register codes, reset values.
// No dependencies.
package dpr_pkg;

	localparam int NUM_CH           = 2;
	localparam int SLOW_TICK_DIVIDE = 256;
	localparam int TICK_W           = (SLOW_TICK_DIVIDE > 2) ? $clog2(SLOW_TICK_DIVIDE) : 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// command codes
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_TRIP = 2'd1;
	localparam logic [1:0] CMD_SET  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LO     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_HI     = 3'd4;

	// reset values
	localparam logic [6:0] RST_RAMP_STEP    = 7'd10;
	localparam logic [7:0] RST_DUTY_CEILING = 8'd250;
	localparam logic [3:0] RST_HOLD_TICKS   = 4'd2;
	localparam logic [7:0] RST_SPEED_LO     = 8'd5;
	localparam logic [7:0] RST_SPEED_HI     = 8'd249;
	localparam logic [7:0] RST_DUTY         = 8'd10;

	typedef struct packed {
		logic [1:0] cmd;
		logic       motor;
		logic [7:0] speed;
		logic       direction;
		logic       enable;
	} req_t;

	typedef struct packed {
		logic [7:0] duty_main;
		logic [7:0] duty_aux;
		logic       dir_main;
		logic       dir_aux;
		logic       en_main;
		logic       en_aux;
		logic       armed_main;
		logic       armed_aux;
		logic       slow_tick;
	} rsp_t;

endpackage

// ----- hdl/dual_pwm_ramp_overcurrent_cutback.sv -----
// Top level of the dual-channel PWM ramp controller with overcurrent cutback.
// Depends on dpr_pkg.
//
// Each request (PWM tick, overcurrent event, or motor command) gives exactly one
// response showing both channels' state after that request. One request is
// accepted every clock cycle while the response side does not stall; an accepted
// request passes through the input register, then the response register that
// also updates the channel state. A stalled response holds one more request in
// the input register before req_ready drops. Register writes take effect at once
// and should be made only while no request is in flight.
module dual_pwm_ramp_overcurrent_cutback (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  dpr_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output dpr_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [dpr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dpr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dpr_pkg::*;

	// configuration
	logic [6:0] ramp_step_q;
	logic [7:0] duty_ceiling_q;
	logic [3:0] hold_ticks_q;
	logic [7:0] speed_lo_q;
	logic [7:0] speed_hi_q;

	// channel state
	logic [7:0] duty_q    [NUM_CH];
	logic [7:0] request_q [NUM_CH];
	logic       dir_q     [NUM_CH];
	logic       en_q      [NUM_CH];
	logic [3:0] hold_q    [NUM_CH];
	logic       armed_q   [NUM_CH];
	logic [TICK_W-1:0] tick_cnt_q;

	logic [7:0] duty_d    [NUM_CH];
	logic [7:0] request_d [NUM_CH];
	logic       dir_d     [NUM_CH];
	logic       en_d      [NUM_CH];
	logic [3:0] hold_d    [NUM_CH];
	logic       armed_d   [NUM_CH];
	logic [TICK_W-1:0] tick_cnt_d;
	logic       slow_d;

	logic [8:0] up_sum  [NUM_CH];
	logic [7:0] up_duty [NUM_CH];
	logic [7:0] dn_sub  [NUM_CH];
	logic [7:0] dn_tgt  [NUM_CH];
	logic [7:0] dn_duty [NUM_CH];

	logic       valid_s1;
	req_t       item_s1;
	logic       advance;
	logic [7:0] clamp_run;
	logic [7:0] clamp_stop;
	logic       tick_last;

	assign advance   = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	function automatic logic [7:0] clamp_speed(input logic [7:0] s, input logic [7:0] lo,
			input logic [7:0] hi);
		logic [7:0] r;
		if (s < lo) begin
			r = lo;
		end else if (s > hi) begin
			r = hi;
		end else begin
			r = s;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q    <= RST_RAMP_STEP;
			duty_ceiling_q <= RST_DUTY_CEILING;
			hold_ticks_q   <= RST_HOLD_TICKS;
			speed_lo_q     <= RST_SPEED_LO;
			speed_hi_q     <= RST_SPEED_HI;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RAMP_STEP:    ramp_step_q    <= cfg_data[6:0];
				REG_DUTY_CEILING: duty_ceiling_q <= cfg_data[7:0];
				REG_HOLD_TICKS:   hold_ticks_q   <= cfg_data[3:0];
				REG_SPEED_LO:     speed_lo_q     <= cfg_data[7:0];
				REG_SPEED_HI:     speed_hi_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	assign clamp_run  = clamp_speed(item_s1.speed, speed_lo_q, speed_hi_q);
	assign clamp_stop = clamp_speed(8'd0, speed_lo_q, speed_hi_q);
	assign tick_last  = tick_cnt_q == TICK_W'(SLOW_TICK_DIVIDE - 1);

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			up_sum[c]  = {1'b0, duty_q[c]} + {2'b00, ramp_step_q};
			up_duty[c] = (up_sum[c] > {1'b0, request_q[c]}) ? request_q[c] : up_sum[c][7:0];
			dn_sub[c]  = (duty_q[c] > {1'b0, ramp_step_q}) ? duty_q[c] - {1'b0, ramp_step_q}
				: 8'd0;
			dn_tgt[c]  = (duty_ceiling_q > request_q[c]) ? duty_ceiling_q - request_q[c] : 8'd0;
			dn_duty[c] = (dn_sub[c] < dn_tgt[c]) ? dn_tgt[c] : dn_sub[c];

			duty_d[c]    = duty_q[c];
			request_d[c] = request_q[c];
			dir_d[c]     = dir_q[c];
			en_d[c]      = en_q[c];
			hold_d[c]    = hold_q[c];
			armed_d[c]   = armed_q[c];

			case (item_s1.cmd)
				CMD_TICK: begin
					if (hold_q[c] != 4'd0) begin
						hold_d[c] = hold_q[c] - 4'd1;
					end else begin
						armed_d[c] = 1'b1;
						duty_d[c]  = dir_q[c] ? dn_duty[c] : up_duty[c];
					end
				end
				CMD_TRIP: begin
					if (item_s1.motor == 1'(c) && armed_q[c]) begin
						duty_d[c]  = dir_q[c] ? duty_ceiling_q : 8'd0;
						hold_d[c]  = hold_ticks_q;
						armed_d[c] = 1'b0;
					end
				end
				CMD_SET: begin
					if (item_s1.motor == 1'(c)) begin
						if (item_s1.enable) begin
							request_d[c] = clamp_run;
							dir_d[c]     = item_s1.direction;
							en_d[c]      = 1'b1;
						end else begin
							request_d[c] = clamp_stop;
							en_d[c]      = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end

		tick_cnt_d = tick_cnt_q;
		slow_d     = 1'b0;
		if (item_s1.cmd == CMD_TICK) begin
			if (tick_last) begin
				slow_d     = 1'b1;
				tick_cnt_d = '0;
			end else begin
				tick_cnt_d = tick_cnt_q + TICK_W'(1);
			end
		end
	end

	// state update and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				duty_q[c]    <= RST_DUTY;
				request_q[c] <= 8'd0;
				dir_q[c]     <= 1'b0;
				en_q[c]      <= 1'b0;
				hold_q[c]    <= 4'd0;
				armed_q[c]   <= 1'b1;
			end
			tick_cnt_q <= '0;
		end else if (advance) begin
			for (int c = 0; c < NUM_CH; c++) begin
				duty_q[c]    <= duty_d[c];
				request_q[c] <= request_d[c];
				dir_q[c]     <= dir_d[c];
				en_q[c]      <= en_d[c];
				hold_q[c]    <= hold_d[c];
				armed_q[c]   <= armed_d[c];
			end
			tick_cnt_q <= tick_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.duty_main  <= duty_d[0];
			rsp.duty_aux   <= duty_d[1];
			rsp.dir_main   <= dir_d[0];
			rsp.dir_aux    <= dir_d[1];
			rsp.en_main    <= en_d[0];
			rsp.en_aux     <= en_d[1];
			rsp.armed_main <= armed_d[0];
			rsp.armed_aux  <= armed_d[1];
			rsp.slow_tick  <= slow_d;
		end
	end

endmodule

// ----- hdl/dpr_checker.sv -----
// Port-level checker for dual_pwm_ramp_overcurrent_cutback, with its bind.
// Depends on dpr_pkg.
module dpr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input dpr_pkg::rsp_t rsp
);
	import dpr_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// a fresh response follows an earlier accepted request
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response without a request");

	// backpressure only when the response side is stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("req_ready low without output stall");

endmodule

bind dual_pwm_ramp_overcurrent_cutback dpr_checker u_dpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ----- bench/dual_pwm_ramp_overcurrent_cutback_tb.sv -----
// Testbench for dual_pwm_ramp_overcurrent_cutback: directed and random requests, with a
// scoreboard class that predicts both channels' state after every request.
// Depends on dpr_pkg and the RTL top level only.
module dual_pwm_ramp_overcurrent_cutback_tb;
	import dpr_pkg::*;

	localparam logic [1:0]           CMD_NONE     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NO_SUCH  = 3'd7;
	localparam int                   CYCLE_LIMIT  = 200000;
	localparam int                   HOLD_OFF_LEN = 80;

	class cutback_scoreboard;
		logic [6:0]        ramp_step;
		logic [7:0]        duty_ceiling;
		logic [3:0]        hold_ticks;
		logic [7:0]        speed_lo;
		logic [7:0]        speed_hi;
		logic [7:0]        duty [NUM_CH];
		logic [7:0]        target_speed [NUM_CH];
		logic              dir_b [NUM_CH];
		logic              running [NUM_CH];
		logic [3:0]        hold_left [NUM_CH];
		logic              armed [NUM_CH];
		logic [TICK_W-1:0] tick_count;
		rsp_t              expected_states [$];
		int                mismatches;

		function new();
			ramp_step    = RST_RAMP_STEP;
			duty_ceiling = RST_DUTY_CEILING;
			hold_ticks   = RST_HOLD_TICKS;
			speed_lo     = RST_SPEED_LO;
			speed_hi     = RST_SPEED_HI;
			for (int c = 0; c < NUM_CH; c++) begin
				duty[c]         = RST_DUTY;
				target_speed[c] = '0;
				dir_b[c]        = 1'b0;
				running[c]      = 1'b0;
				hold_left[c]    = '0;
				armed[c]        = 1'b1;
			end
			tick_count = '0;
			mismatches = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_RAMP_STEP:    ramp_step    = val[6:0];
				REG_DUTY_CEILING: duty_ceiling = val;
				REG_HOLD_TICKS:   hold_ticks   = val[3:0];
				REG_SPEED_LO:     speed_lo     = val;
				REG_SPEED_HI:     speed_hi     = val;
				default: ;
			endcase
		endfunction

		function logic [7:0] clamp_speed(logic [7:0] s);
			if (s < speed_lo)
				return speed_lo;
			if (s > speed_hi)
				return speed_hi;
			return s;
		endfunction

		function void ramp_channel(int c);
			int t;
			int floor_duty;
			if (hold_left[c] != 0) begin
				hold_left[c] = hold_left[c] - 4'd1;
				return;
			end
			armed[c] = 1'b1;
			if (!dir_b[c]) begin
				t = int'(duty[c]) + int'(ramp_step);
				if (t > int'(target_speed[c]))
					t = int'(target_speed[c]);
			end else begin
				floor_duty = (duty_ceiling > target_speed[c]) ?
					int'(duty_ceiling) - int'(target_speed[c]) : 0;
				t = (duty[c] > ramp_step) ? int'(duty[c]) - int'(ramp_step) : 0;
				if (t < floor_duty)
					t = floor_duty;
			end
			duty[c] = t[7:0];
		endfunction

		function void note_request(req_t r);
			rsp_t s;
			logic slow;
			int   m;
			slow = 1'b0;
			m    = int'(r.motor);
			case (r.cmd)
				CMD_TICK: begin
					ramp_channel(0);
					ramp_channel(1);
					if (int'(tick_count) >= SLOW_TICK_DIVIDE - 1) begin
						slow       = 1'b1;
						tick_count = '0;
					end else begin
						tick_count = tick_count + TICK_W'(1);
					end
				end
				CMD_TRIP: begin
					if (armed[m]) begin
						duty[m]      = dir_b[m] ? duty_ceiling : 8'd0;
						hold_left[m] = hold_ticks;
						armed[m]     = 1'b0;
					end
				end
				CMD_SET: begin
					if (r.enable) begin
						target_speed[m] = clamp_speed(r.speed);
						dir_b[m]        = r.direction;
						running[m]      = 1'b1;
					end else begin
						target_speed[m] = clamp_speed(8'd0);
						running[m]      = 1'b0;
					end
				end
				default: ;
			endcase
			s.duty_main  = duty[0];
			s.duty_aux   = duty[1];
			s.dir_main   = dir_b[0];
			s.dir_aux    = dir_b[1];
			s.en_main    = running[0];
			s.en_aux     = running[1];
			s.armed_main = armed[0];
			s.armed_aux  = armed[1];
			s.slow_tick  = slow;
			expected_states.push_back(s);
		endfunction

		function void check_response(rsp_t r);
			rsp_t e;
			if (expected_states.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: response with no request outstanding: %h", r);
				return;
			end
			e = expected_states.pop_front();
			if (r !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp duty %0d/%0d dir %b%b en %b%b armed %b%b slow %b",
						" | got duty %0d/%0d dir %b%b en %b%b armed %b%b slow %b"},
						e.duty_main, e.duty_aux, e.dir_main, e.dir_aux, e.en_main,
						e.en_aux, e.armed_main, e.armed_aux, e.slow_tick,
						r.duty_main, r.duty_aux, r.dir_main, r.dir_aux, r.en_main,
						r.en_aux, r.armed_main, r.armed_aux, r.slow_tick);
			end
		endfunction

		function int pending();
			return expected_states.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_t                  rsp;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	cutback_scoreboard sb;
	bit                calm;
	bit                hold_off_req;
	int                cycle_count;

	dual_pwm_ramp_overcurrent_cutback u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	// response side: random stalls, one long hold-off on request
	initial begin : rsp_side
		bit held_off;
		held_off  = 1'b0;
		rsp_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_req && !held_off) begin
				held_off = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic send_request(input req_t item);
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic send_fields(input logic [1:0] cmd, input logic motor,
			input logic [7:0] speed, input logic direction, input logic enable);
		req_t item;
		item.cmd       = cmd;
		item.motor     = motor;
		item.speed     = speed;
		item.direction = direction;
		item.enable    = enable;
		send_request(item);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic apply_setting(input logic [7:0] step, input logic [7:0] ceiling,
			input logic [7:0] hold, input logic [7:0] lo, input logic [7:0] hi);
		drain();
		write_reg(REG_RAMP_STEP, step);
		write_reg(REG_DUTY_CEILING, ceiling);
		write_reg(REG_HOLD_TICKS, hold);
		write_reg(REG_SPEED_LO, lo);
		write_reg(REG_SPEED_HI, hi);
		write_reg(REG_NO_SUCH, 8'($urandom_range(0, 255)));
		cfg_we <= 1'b0;
	endtask

	function automatic req_t make_item();
		req_t item;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			item.cmd = CMD_TICK;
		else if (pick < 75)
			item.cmd = CMD_TRIP;
		else if (pick < 96)
			item.cmd = CMD_SET;
		else
			item.cmd = CMD_NONE;
		item.motor = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0: item.speed = 8'd0;
			1: item.speed = 8'd255;
			2: item.speed = sb.speed_lo;
			3: item.speed = sb.speed_hi;
			default: item.speed = 8'($urandom_range(0, 255));
		endcase
		item.direction = 1'($urandom_range(0, 1));
		item.enable    = ($urandom_range(0, 4) != 0);
		return item;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			send_request(make_item());
	endtask

	initial begin
		sb           = new();
		calm         = 1'b0;
		hold_off_req = 1'b0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_data     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset configuration
		send_fields(CMD_TICK, 1'b1, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TRIP, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TRIP, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_SET, 1'b0, 8'd255, 1'b0, 1'b1);
		send_fields(CMD_SET, 1'b1, 8'd0, 1'b1, 1'b1);
		send_fields(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TICK, 1'b1, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TRIP, 1'b1, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TRIP, 1'b1, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_NONE, 1'b1, 8'd255, 1'b1, 1'b1);
		send_fields(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_SET, 1'b1, 8'd128, 1'b1, 1'b1);
		send_fields(CMD_SET, 1'b0, 8'd3, 1'b1, 1'b1);
		send_fields(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_SET, 1'b0, 8'd255, 1'b1, 1'b0);
		send_fields(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0);
		send_fields(CMD_SET, 1'b1, 8'd170, 1'b0, 1'b1);
		send_fields(CMD_TICK, 1'b1, 8'd85, 1'b1, 1'b1);

		apply_setting(8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
		run_random(70);

		apply_setting(8'hC0, 8'd255, 8'd15, 8'd255, 8'd255);
		hold_off_req = 1'b1;
		run_random(70);

		// min above max, step beyond its range
		apply_setting(8'hFF, 8'd128, 8'hF1, 8'd200, 8'd50);
		run_random(70);

		apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		run_random(70);

		apply_setting(8'($urandom_range(1, 64)), 8'($urandom_range(1, 255)),
			8'($urandom_range(0, 15)), 8'($urandom_range(0, 60)),
			8'($urandom_range(150, 255)));
		run_random(70);

		apply_setting(8'd10, 8'd250, 8'd2, 8'd5, 8'd249);
		calm = 1'b1;
		run_random(70);

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
